// ----- rtl/gn_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gn_pkg: shared types and constants of the gradient noise block
// Item codes, table geometry and the record passed from front to back.
// ----------------------------------------------------------------------------
package gn_pkg;

   // table geometry: indices wrap modulo the table size
   localparam int TABLE_SIZE    = 256;
   localparam int IDX_W         = $clog2(TABLE_SIZE);
   localparam int COORD_OFFSET  = 4096;
   localparam int QUEUE_DEPTH   = 4;

   // datapath widths
   localparam int LERP_W        = 22;
   localparam int OUT_W         = 18;
   localparam int OUT_MAX       = 131071;
   localparam int OUT_MIN       = -131072;

   typedef enum logic [1:0] {
      FUNC_WR_PERM = 2'd0,
      FUNC_WR_GRAD = 2'd1,
      FUNC_EVAL_1D = 2'd2,
      FUNC_EVAL_2D = 2'd3
   } func_type;

   // classified and split item
   typedef struct packed {
      func_type          func;
      logic [IDX_W-1:0]  bx0;
      logic [IDX_W-1:0]  bx1;
      logic [15:0]       rx;
      logic [IDX_W-1:0]  by0;
      logic [IDX_W-1:0]  by1;
      logic [15:0]       ry;
      logic [IDX_W-1:0]  idx;
      logic [15:0]       va;
      logic [15:0]       vb;
      logic [15:0]       vc;
   } item_type;

endpackage
`default_nettype wire

// ----- rtl/gradient_noise_1d_2d.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gradient_noise_1d_2d: 1D and 2D lattice gradient noise
// Table writes and noise evaluations share one in-order item stream.
//
//   channel   direction   beat contents
//   req_      in          func, coord_x, coord_y, table_index, values a/b/c
//   rsp_      out         noise_value (evaluate items only)
//
// One item per cycle sustained while rsp_ready holds; an accepted item is first
// registered in the queue, then passes through the six-register lookup and
// interpolation pipeline.
// Reset clears control only; tables hold no reset value and must be loaded.
// A stalled result stops the back end; the four-entry queue keeps req_ready
// high until it fills.
// ----------------------------------------------------------------------------
module gradient_noise_1d_2d #(
   parameter int COORD_OFFSET = gn_pkg::COORD_OFFSET
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_func,
   input  wire logic signed [31:0]            req_coord_x,
   input  wire logic signed [31:0]            req_coord_y,
   input  wire logic [7:0]                    req_table_index,
   input  wire logic signed [15:0]            req_table_value_a,
   input  wire logic signed [15:0]            req_table_value_b,
   input  wire logic signed [15:0]            req_table_value_c,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [gn_pkg::OUT_W-1:0]    rsp_noise_value
);

   gn_pkg::item_type front_item;
   gn_pkg::item_type q_item;
   logic             q_full;
   logic             q_empty;
   logic             q_pop;
   logic             push;

   assign req_ready = !q_full;
   assign push      = req_valid && !q_full;

   gn_front #(.COORD_OFFSET(COORD_OFFSET)) u_front (
      .req_func          (req_func),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .req_table_index   (req_table_index),
      .req_table_value_a (req_table_value_a),
      .req_table_value_b (req_table_value_b),
      .req_table_value_c (req_table_value_c),
      .item              (front_item)
   );

   gn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_item),
      .empty     (q_empty)
   );

   gn_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_item          (q_item),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_noise_value (rsp_noise_value)
   );

endmodule
`default_nettype wire

// ----- rtl/gn_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gn_front: input classification and coordinate split
// Offsets each coordinate and splits it into lattice cell and fraction.
// ----------------------------------------------------------------------------
module gn_front #(
   parameter int COORD_OFFSET = gn_pkg::COORD_OFFSET
) (
   input  wire logic [1:0]            req_func,
   input  wire logic signed [31:0]    req_coord_x,
   input  wire logic signed [31:0]    req_coord_y,
   input  wire logic [7:0]            req_table_index,
   input  wire logic signed [15:0]    req_table_value_a,
   input  wire logic signed [15:0]    req_table_value_b,
   input  wire logic signed [15:0]    req_table_value_c,
   output gn_pkg::item_type           item
);

   localparam logic signed [33:0] OFFSET_Q16 = 34'(COORD_OFFSET) <<< 16;

   logic signed [33:0] tx;
   logic signed [33:0] ty;

   // offset coordinates; floor cell is the arithmetic upper part
   always_comb begin
      tx = 34'(req_coord_x) + OFFSET_Q16;
      ty = 34'(req_coord_y) + OFFSET_Q16;
      item.func = gn_pkg::func_type'(req_func);
      item.bx0  = tx[16 +: gn_pkg::IDX_W];
      item.bx1  = tx[16 +: gn_pkg::IDX_W] + gn_pkg::IDX_W'(1);
      item.rx   = tx[15:0];
      item.by0  = ty[16 +: gn_pkg::IDX_W];
      item.by1  = ty[16 +: gn_pkg::IDX_W] + gn_pkg::IDX_W'(1);
      item.ry   = ty[15:0];
      item.idx  = gn_pkg::IDX_W'(req_table_index);
      item.va   = req_table_value_a;
      item.vb   = req_table_value_b;
      item.vc   = req_table_value_c;
   end

endmodule
`default_nettype wire

// ----- rtl/gn_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gn_queue: short item queue between front and back
// Lets the input side keep accepting while the back end stalls.
// ----------------------------------------------------------------------------
module gn_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire gn_pkg::item_type  push_item,
   output logic                   full,
   input  wire logic              pop,
   output gn_pkg::item_type       pop_item,
   output logic                   empty
);

   localparam int PTR_W = $clog2(gn_pkg::QUEUE_DEPTH);

   gn_pkg::item_type   slot_ff [gn_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;

   // advance pointers and count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the beat
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item = slot_ff[rd_ptr_ff];
   assign full     = (count_ff == (PTR_W+1)'(gn_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);

endmodule
`default_nettype wire

// ----- rtl/gn_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gn_back: table lookup, gradient and interpolation pipeline
// Six stages under one enable; each table copy is written at the stage that
// reads it, so writes and lookups stay in item order.
// ----------------------------------------------------------------------------
module gn_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire gn_pkg::item_type               q_item,
   input  wire logic                           q_empty,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic signed [gn_pkg::OUT_W-1:0]     rsp_noise_value
);

   localparam int IW = gn_pkg::IDX_W;
   localparam int LW = gn_pkg::LERP_W;
   localparam int TS = gn_pkg::TABLE_SIZE;

   // table copies, two read ports each
   logic [7:0]  perm_a [TS];
   logic [7:0]  perm_b [TS];
   logic [7:0]  perm_c [TS];
   logic [15:0] grad1  [TS];
   logic [31:0] grad2_x[TS];
   logic [31:0] grad2_y[TS];

   logic en;

   // stage 1
   logic               s1_valid_ff;
   gn_pkg::item_type   s1_item_ff;
   logic [7:0]         s1_p0_ff, s1_p1_ff;
   logic [31:0]        s1_sqx_ff, s1_sqy_ff;
   // stage 2
   logic               s2_valid_ff;
   gn_pkg::item_type   s2_item_ff;
   logic [7:0]         s2_h00_ff, s2_h10_ff, s2_h01_ff, s2_h11_ff;
   logic [15:0]        s2_g0_ff, s2_g1_ff;
   logic [16:0]        s2_fx_ff, s2_fy_ff;
   logic [49:0]        fade_x, fade_y;
   // stage 3
   logic               s3_valid_ff;
   gn_pkg::item_type   s3_item_ff;
   logic [31:0]        s3_q00_ff, s3_q10_ff, s3_q01_ff, s3_q11_ff;
   logic [15:0]        s3_g0_ff, s3_g1_ff;
   logic [16:0]        s3_fx_ff, s3_fy_ff;
   // stage 4
   logic               s4_valid_ff;
   gn_pkg::func_type   s4_func_ff;
   logic signed [LW-1:0] s4_d00_ff, s4_d10_ff, s4_d01_ff, s4_d11_ff;
   logic [16:0]        s4_fx_ff, s4_fy_ff;
   logic signed [LW-1:0] d00_in, d10_in, d01_in, d11_in;
   // stage 5
   logic               s5_valid_ff;
   gn_pkg::func_type   s5_func_ff;
   logic signed [LW-1:0] s5_a_ff, s5_b_ff;
   logic [16:0]        s5_fy_ff;
   // output
   logic               rsp_valid_ff;
   logic signed [gn_pkg::OUT_W-1:0] rsp_value_ff;
   logic signed [LW-1:0] n_in;
   logic signed [gn_pkg::OUT_W-1:0] sat_in;

   // floor((r*gx + r2*gy) / 2^15)
   function automatic logic signed [LW-1:0] dot(
      input logic signed [16:0] rx, input logic signed [15:0] gx,
      input logic signed [16:0] ry, input logic signed [15:0] gy);
      logic signed [33:0] s;
      s = rx * gx + ry * gy;
      return LW'(s >>> 15);
   endfunction

   // a + floor(t * (b - a) / 2^16)
   function automatic logic signed [LW-1:0] lerp(
      input logic [16:0] t,
      input logic signed [LW-1:0] a, input logic signed [LW-1:0] b);
      logic signed [LW:0]    d;
      logic signed [LW+18:0] p;
      d = (LW+1)'(b) - (LW+1)'(a);
      p = d * $signed({1'b0, t});
      return a + LW'(p >>> 16);
   endfunction

   assign en    = !rsp_valid_ff || rsp_ready;
   assign q_pop = en && !q_empty;

   // stage 1: first permutation lookup, fraction squares
   always_ff @(posedge clock) begin
      if (en) begin
         s1_item_ff <= q_item;
         s1_p0_ff   <= perm_a[q_item.bx0];
         s1_p1_ff   <= perm_a[q_item.bx1];
         s1_sqx_ff  <= q_item.rx * q_item.rx;
         s1_sqy_ff  <= q_item.ry * q_item.ry;
         if (!q_empty && q_item.func == gn_pkg::FUNC_WR_PERM) begin
            perm_a[q_item.idx] <= q_item.va[7:0];
         end
      end
   end

   // stage 2: corner hashes, 1D gradients, fade
   always_comb begin
      fade_x = s1_sqx_ff * (18'd196608 - {1'b0, s1_item_ff.rx, 1'b0});
      fade_y = s1_sqy_ff * (18'd196608 - {1'b0, s1_item_ff.ry, 1'b0});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_item_ff <= s1_item_ff;
         s2_h00_ff  <= perm_b[IW'(s1_p0_ff + s1_item_ff.by0)];
         s2_h10_ff  <= perm_b[IW'(s1_p1_ff + s1_item_ff.by0)];
         s2_h01_ff  <= perm_c[IW'(s1_p0_ff + s1_item_ff.by1)];
         s2_h11_ff  <= perm_c[IW'(s1_p1_ff + s1_item_ff.by1)];
         s2_g0_ff   <= grad1[IW'(s1_p0_ff)];
         s2_g1_ff   <= grad1[IW'(s1_p1_ff)];
         s2_fx_ff   <= fade_x[48:32];
         s2_fy_ff   <= fade_y[48:32];
         if (s1_valid_ff && s1_item_ff.func == gn_pkg::FUNC_WR_PERM) begin
            perm_b[s1_item_ff.idx] <= s1_item_ff.va[7:0];
            perm_c[s1_item_ff.idx] <= s1_item_ff.va[7:0];
         end
         if (s1_valid_ff && s1_item_ff.func == gn_pkg::FUNC_WR_GRAD) begin
            grad1[s1_item_ff.idx] <= s1_item_ff.va;
         end
      end
   end

   // stage 3: 2D gradient lookup
   always_ff @(posedge clock) begin
      if (en) begin
         s3_item_ff <= s2_item_ff;
         s3_q00_ff  <= grad2_x[IW'(s2_h00_ff)];
         s3_q10_ff  <= grad2_x[IW'(s2_h10_ff)];
         s3_q01_ff  <= grad2_y[IW'(s2_h01_ff)];
         s3_q11_ff  <= grad2_y[IW'(s2_h11_ff)];
         s3_g0_ff   <= s2_g0_ff;
         s3_g1_ff   <= s2_g1_ff;
         s3_fx_ff   <= s2_fx_ff;
         s3_fy_ff   <= s2_fy_ff;
         if (s2_valid_ff && s2_item_ff.func == gn_pkg::FUNC_WR_GRAD) begin
            grad2_x[s2_item_ff.idx] <= {s2_item_ff.vc, s2_item_ff.vb};
            grad2_y[s2_item_ff.idx] <= {s2_item_ff.vc, s2_item_ff.vb};
         end
      end
   end

   // stage 4: gradient dot products; r1 is r0 - 1 in Q.16
   always_comb begin
      logic signed [16:0] rx0, rx1, ry0, ry1;
      rx0 = $signed({1'b0, s3_item_ff.rx});
      rx1 = $signed({1'b1, s3_item_ff.rx});
      ry0 = $signed({1'b0, s3_item_ff.ry});
      ry1 = $signed({1'b1, s3_item_ff.ry});
      if (s3_item_ff.func == gn_pkg::FUNC_EVAL_2D) begin
         d00_in = dot(rx0, s3_q00_ff[15:0], ry0, s3_q00_ff[31:16]);
         d10_in = dot(rx1, s3_q10_ff[15:0], ry0, s3_q10_ff[31:16]);
         d01_in = dot(rx0, s3_q01_ff[15:0], ry1, s3_q01_ff[31:16]);
         d11_in = dot(rx1, s3_q11_ff[15:0], ry1, s3_q11_ff[31:16]);
      end else begin
         d00_in = dot(rx0, s3_g0_ff, 17'sd0, 16'sd0);
         d10_in = dot(rx1, s3_g1_ff, 17'sd0, 16'sd0);
         d01_in = '0;
         d11_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_func_ff <= s3_item_ff.func;
         s4_d00_ff  <= d00_in;
         s4_d10_ff  <= d10_in;
         s4_d01_ff  <= d01_in;
         s4_d11_ff  <= d11_in;
         s4_fx_ff   <= s3_fx_ff;
         s4_fy_ff   <= s3_fy_ff;
      end
   end

   // stage 5: interpolate along x
   always_ff @(posedge clock) begin
      if (en) begin
         s5_func_ff <= s4_func_ff;
         s5_a_ff    <= lerp(s4_fx_ff, s4_d00_ff, s4_d10_ff);
         s5_b_ff    <= lerp(s4_fx_ff, s4_d01_ff, s4_d11_ff);
         s5_fy_ff   <= s4_fy_ff;
      end
   end

   // output: interpolate along y (2D only) and saturate
   always_comb begin
      n_in = (s5_func_ff == gn_pkg::FUNC_EVAL_2D) ? lerp(s5_fy_ff, s5_a_ff, s5_b_ff)
                                                  : s5_a_ff;
      priority if (n_in > LW'(gn_pkg::OUT_MAX)) begin
         sat_in = gn_pkg::OUT_W'(gn_pkg::OUT_MAX);
      end else if (n_in < LW'(gn_pkg::OUT_MIN)) begin
         sat_in = gn_pkg::OUT_W'(gn_pkg::OUT_MIN);
      end else begin
         sat_in = n_in[gn_pkg::OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_value_ff <= sat_in;
      end
   end

   // advance stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= !q_empty;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         rsp_valid_ff <= s5_valid_ff && (s5_func_ff == gn_pkg::FUNC_EVAL_1D ||
                                         s5_func_ff == gn_pkg::FUNC_EVAL_2D);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_value_ff;

endmodule
`default_nettype wire
